/* design/etc1s_bir_pkg.sv */
// shared types and constants for the etc1s block index rebuild
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package etc1s_bir_pkg;

    localparam int MAX_COLS      = 1024;
    localparam int HISTORY_DEPTH = 512;
    localparam int COL_W         = $clog2(MAX_COLS);
    localparam int ROW_AW        = COL_W + 1;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    localparam logic [31:0] PRED_SYMBOL_COUNT = 32'd257;
    localparam logic [31:0] PRED_ESCAPE       = PRED_SYMBOL_COUNT - 32'd1;
    localparam int          RUN_ESCAPE_WIDTH  = 6;
    localparam logic [31:0] RUN_ESCAPE        = (32'd1 << RUN_ESCAPE_WIDTH) - 32'd1;
    // repeat count is vlc + 2 saturating, run count is value + 3 saturating and then - 1
    localparam logic [31:0] REPEAT_SAT_LIMIT  = 32'hFFFF_FFFD;
    localparam logic [31:0] RUN_SAT_LIMIT     = 32'hFFFF_FFFC;
    localparam logic [31:0] RUN_SAT_VALUE     = 32'hFFFF_FFFE;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_EP     = 3'd2;
    localparam logic [2:0] CFG_SEL    = 3'd3;
    localparam logic [2:0] CFG_HIST   = 3'd4;

    typedef enum logic [2:0] {
        K_PRED,
        K_REPEAT,
        K_DELTA,
        K_SELECTOR,
        K_RUN,
        K_RUNVLC,
        K_ADVANCE,
        K_START
    } kind_t;

    // need code for a finished, failed or idle slice
    localparam kind_t K_DONE = K_START;

    typedef enum logic [2:0] {
        ST_PRED,
        ST_REPEAT,
        ST_ENDPOINT,
        ST_SELECTOR,
        ST_RUN,
        ST_RUNVLC,
        ST_FINISH
    } stage_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_CLEAR,
        SQ_STEP,
        SQ_STASH,
        SQ_ROW,
        SQ_HRD,
        SQ_HWR
    } seq_t;

endpackage

`default_nettype wire

/* design/etc1s_block_index_reconstruct.sv */
// etc1s block index rebuild: tokens in, one result per token out
// row store, prediction stash and selector history memories live here
// depends on etc1s_bir_pkg
//
// token channel: token_valid / token_stall carry kind and token_value. a
// one-entry input register takes a request, then token_stall stays high until
// the sequencer has pulled it. result channel: result_valid / result_stall
// carry one result per request from an output register, so a new request is
// taken while a result still waits.
// a request passes the input register, then the sequencer steps through each
// stage; a stash or row store read adds the SQ_STASH or SQ_ROW state, and a
// history read with swap adds SQ_HRD and SQ_HWR. a request that also finishes a
// block walks on through the stages of the next one before its result is set.
// slice start: the result appears in the next cycle, then a clearing pass
// writes every entry of the history memory to zero; no request is taken then.
// reset clears control state; the result registers are not reset, so need_kind is undefined until the first result.
// result_stall holds the output register; the sequencer waits for room
// before it starts on the next request.
// cfg_ready is always high; write registers only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module etc1s_block_index_reconstruct
    import etc1s_bir_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        token_valid,
    output logic             token_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] token_value,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             block_valid,
    output logic [15:0]      endpoint_index,
    output logic [15:0]      selector_index,
    output logic [2:0]       need_kind,
    output logic             error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [10:0] cfg_w_reg;
    logic [15:0] cfg_h_reg, cfg_ep_reg, cfg_sel_reg;
    logic [9:0]  cfg_hist_reg;

    logic [10:0] lat_w_reg, lat_w_next;
    logic [15:0] lat_h_reg, lat_h_next, lat_ep_reg, lat_ep_next, lat_sel_reg, lat_sel_next;
    logic [9:0]  lat_hist_reg, lat_hist_next;

    seq_t   seq_reg, seq_next;
    stage_t stage_reg, stage_next;
    kind_t  phase_reg, phase_next;
    logic   err_reg, err_next;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [15:0]        row_reg, row_next;
    logic [7:0]         pend_reg, pend_next, last_sym_reg, last_sym_next;
    logic [31:0]        rep_left_reg, rep_left_next, run_left_reg, run_left_next;
    logic [15:0]        last_ep_reg, last_ep_next;
    logic [1:0]         cur_pred_reg, cur_pred_next;
    logic [32:0]        cur_ep_reg, cur_ep_next;
    logic [15:0]        cur_sel_reg, cur_sel_next;
    logic               tok_have_reg, tok_have_next, may_end_reg, may_end_next;
    logic [31:0]        tok_val_reg, tok_val_next;
    logic [HIST_AW-1:0] slot_reg, slot_next, clr_reg, clr_next;
    logic [15:0]        swap_reg, swap_next;
    logic [HIST_AW:0]   rover_reg, rover_next;
    logic               emitted_reg, emitted_next;
    logic [15:0]        emit_ep_reg, emit_ep_next, emit_sel_reg, emit_sel_next;

    logic        ib_valid_reg;
    kind_t       ib_kind_reg;
    logic [31:0] ib_value_reg;

    logic        ov_reg, o_block_reg, o_err_reg;
    logic [15:0] o_ep_reg, o_sel_reg;
    kind_t       o_need_reg;

    logic go_ret, go_run, go_clear, go_stash, go_row, go_hist, ib_take, out_free;

    logic [15:0] row_mem [2*MAX_COLS];
    logic [3:0]  stash_mem [MAX_COLS];
    logic [15:0] hist_mem [HISTORY_DEPTH];

    logic              row_we, stash_we, hist_we;
    logic [ROW_AW-1:0] row_wa, row_ra;
    logic [15:0]       row_wd, row_q;
    logic [3:0]        stash_wd, stash_q;
    logic [HIST_AW-1:0] hist_wa, hist_ra_a, hist_ra_b;
    logic [15:0]       hist_wd, hist_qa, hist_qb;

    logic              bad_cfg, empty_cfg, pos_bad;
    logic [32:0]       e_sum, e_delta;
    logic [COL_W:0]    col_inc;
    logic [16:0]       row_inc;
    logic [31:0]       slot_full;
    logic [16:0]       run_code;
    logic [HIST_AW:0]  rover_inc;
    logic [31:0]       run_cnt;

    assign cfg_ready = 1'b1;
    assign token_stall = ib_valid_reg;
    assign out_free = ~ov_reg | ~result_stall;

    assign result_valid   = ov_reg;
    assign block_valid    = o_block_reg;
    assign endpoint_index = o_ep_reg;
    assign selector_index = o_sel_reg;
    assign need_kind      = o_need_reg;
    assign error          = o_err_reg;

    assign bad_cfg = (cfg_w_reg > 11'(MAX_COLS)) || (cfg_hist_reg > 10'(HISTORY_DEPTH))
                     || (cfg_ep_reg == 16'd0) || (cfg_sel_reg == 16'd0);
    assign empty_cfg = (cfg_w_reg == 11'd0) || (cfg_h_reg == 16'd0);

    assign e_sum = {1'b0, tok_val_reg} + {17'd0, last_ep_reg};
    assign e_delta = (e_sum >= {17'd0, lat_ep_reg}) ? (e_sum - {17'd0, lat_ep_reg}) : e_sum;
    assign pos_bad = ((cur_pred_reg != 2'd1) && (col_reg == '0))
                     || ((cur_pred_reg != 2'd0) && (row_reg == 16'd0));
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 17'd1;
    assign slot_full = tok_val_reg - {16'd0, lat_sel_reg};
    assign run_code = {1'b0, lat_sel_reg} + {7'd0, lat_hist_reg};
    assign rover_inc = rover_reg + 1'b1;
    assign run_cnt = (tok_val_reg > RUN_SAT_LIMIT) ? RUN_SAT_VALUE : tok_val_reg + 32'd2;

    assign row_ra = {~row_reg[0], (cur_pred_reg == 2'd1) ? col_reg : col_reg - 1'b1};
    assign hist_ra_a = slot_next;
    assign hist_ra_b = slot_next >> 1;

    // datapath and memory control
    always_comb
    begin
        lat_w_next = lat_w_reg; lat_h_next = lat_h_reg; lat_ep_next = lat_ep_reg;
        lat_sel_next = lat_sel_reg; lat_hist_next = lat_hist_reg;
        stage_next = stage_reg; phase_next = phase_reg; err_next = err_reg;
        col_next = col_reg; row_next = row_reg; pend_next = pend_reg;
        last_sym_next = last_sym_reg; rep_left_next = rep_left_reg;
        run_left_next = run_left_reg; last_ep_next = last_ep_reg;
        cur_pred_next = cur_pred_reg; cur_ep_next = cur_ep_reg; cur_sel_next = cur_sel_reg;
        tok_have_next = tok_have_reg; tok_val_next = tok_val_reg; may_end_next = may_end_reg;
        slot_next = slot_reg; swap_next = swap_reg; rover_next = rover_reg;
        clr_next = clr_reg; emitted_next = emitted_reg;
        emit_ep_next = emit_ep_reg; emit_sel_next = emit_sel_reg;
        go_ret = 1'b0; go_run = 1'b0; go_clear = 1'b0;
        go_stash = 1'b0; go_row = 1'b0; go_hist = 1'b0; ib_take = 1'b0;
        row_we = 1'b0; row_wa = {row_reg[0], col_reg}; row_wd = row_q;
        stash_we = 1'b0; stash_wd = last_sym_reg[7:4];
        hist_we = 1'b0; hist_wa = slot_reg; hist_wd = swap_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (ib_valid_reg && out_free)
                begin
                    ib_take = 1'b1;
                    emitted_next = 1'b0;
                    emit_ep_next = 16'd0;
                    emit_sel_next = 16'd0;
                    if (ib_kind_reg == K_START)
                    begin
                        lat_w_next = cfg_w_reg; lat_h_next = cfg_h_reg;
                        lat_ep_next = cfg_ep_reg; lat_sel_next = cfg_sel_reg;
                        lat_hist_next = cfg_hist_reg;
                        rover_next = {1'b0, cfg_hist_reg[9:1]};
                        col_next = '0; row_next = 16'd0; pend_next = 8'd0;
                        last_sym_next = 8'd0; rep_left_next = 32'd0; run_left_next = 32'd0;
                        last_ep_next = 16'd0; stage_next = ST_PRED; cur_pred_next = 2'd0;
                        cur_sel_next = 16'd0; cur_ep_next = 33'd0;
                        tok_have_next = 1'b0; may_end_next = 1'b0;
                        err_next = bad_cfg;
                        phase_next = (bad_cfg || empty_cfg) ? K_DONE : K_PRED;
                        clr_next = '0;
                        go_clear = 1'b1;
                        go_ret = 1'b1;
                    end
                    else if ((ib_kind_reg == phase_reg) && (ib_kind_reg != K_ADVANCE))
                    begin
                        tok_have_next = 1'b1;
                        tok_val_next = ib_value_reg;
                        may_end_next = 1'b1;
                        go_run = 1'b1;
                    end
                    else if ((ib_kind_reg == K_ADVANCE) && (phase_reg == K_ADVANCE))
                    begin
                        tok_have_next = 1'b0;
                        may_end_next = 1'b1;
                        go_run = 1'b1;
                    end
                    else
                    begin
                        go_ret = 1'b1;
                    end
                end
            end
            SQ_CLEAR:
            begin
                hist_we = 1'b1;
                hist_wa = clr_reg;
                hist_wd = 16'd0;
                clr_next = clr_reg + 1'b1;
            end
            SQ_STEP:
            begin
                case (stage_reg)
                    ST_PRED:
                    begin
                        if (col_reg[0])
                        begin
                            cur_pred_next = pend_reg[1:0];
                            pend_next = {2'd0, pend_reg[7:2]};
                            stage_next = ST_ENDPOINT;
                        end
                        else if (row_reg[0])
                        begin
                            go_stash = 1'b1;
                        end
                        else if (rep_left_reg != 32'd0)
                        begin
                            rep_left_next = rep_left_reg - 32'd1;
                            stash_we = 1'b1;
                            stash_wd = last_sym_reg[7:4];
                            cur_pred_next = last_sym_reg[1:0];
                            pend_next = {2'd0, last_sym_reg[7:2]};
                            stage_next = ST_ENDPOINT;
                        end
                        else if (!tok_have_reg)
                        begin
                            phase_next = K_PRED;
                            go_ret = 1'b1;
                        end
                        else
                        begin
                            tok_have_next = 1'b0;
                            if (tok_val_reg >= PRED_SYMBOL_COUNT)
                            begin
                                err_next = 1'b1; phase_next = K_DONE; go_ret = 1'b1;
                            end
                            else if (tok_val_reg == PRED_ESCAPE)
                            begin
                                stage_next = ST_REPEAT;
                            end
                            else
                            begin
                                last_sym_next = tok_val_reg[7:0];
                                stash_we = 1'b1;
                                stash_wd = tok_val_reg[7:4];
                                cur_pred_next = tok_val_reg[1:0];
                                pend_next = {2'd0, tok_val_reg[7:2]};
                                stage_next = ST_ENDPOINT;
                            end
                        end
                    end
                    ST_REPEAT:
                    begin
                        if (!tok_have_reg)
                        begin
                            phase_next = K_REPEAT;
                            go_ret = 1'b1;
                        end
                        else
                        begin
                            tok_have_next = 1'b0;
                            rep_left_next = (tok_val_reg > REPEAT_SAT_LIMIT) ? 32'hFFFF_FFFF
                                            : tok_val_reg + 32'd2;
                            stash_we = 1'b1;
                            stash_wd = last_sym_reg[7:4];
                            cur_pred_next = last_sym_reg[1:0];
                            pend_next = {2'd0, last_sym_reg[7:2]};
                            stage_next = ST_ENDPOINT;
                        end
                    end
                    ST_ENDPOINT:
                    begin
                        if (cur_pred_reg == 2'd3)
                        begin
                            if (!tok_have_reg)
                            begin
                                phase_next = K_DELTA;
                                go_ret = 1'b1;
                            end
                            else
                            begin
                                tok_have_next = 1'b0;
                                row_we = 1'b1;
                                row_wd = e_delta[15:0];
                                last_ep_next = e_delta[15:0];
                                cur_ep_next = e_delta;
                                stage_next = ST_SELECTOR;
                            end
                        end
                        else if (pos_bad)
                        begin
                            if (!may_end_reg)
                            begin
                                phase_next = K_ADVANCE;
                            end
                            else
                            begin
                                err_next = 1'b1; phase_next = K_DONE;
                            end
                            go_ret = 1'b1;
                        end
                        else if (cur_pred_reg == 2'd0)
                        begin
                            row_we = 1'b1;
                            row_wd = last_ep_reg;
                            cur_ep_next = {17'd0, last_ep_reg};
                            stage_next = ST_SELECTOR;
                        end
                        else
                        begin
                            go_row = 1'b1;
                        end
                    end
                    ST_SELECTOR:
                    begin
                        if (run_left_reg != 32'd0)
                        begin
                            if (lat_hist_reg == 10'd0)
                            begin
                                if (!may_end_reg)
                                begin
                                    phase_next = K_ADVANCE;
                                end
                                else
                                begin
                                    err_next = 1'b1; phase_next = K_DONE;
                                end
                                go_ret = 1'b1;
                            end
                            else
                            begin
                                run_left_next = run_left_reg - 32'd1;
                                slot_next = '0;
                                go_hist = 1'b1;
                            end
                        end
                        else if (!tok_have_reg)
                        begin
                            phase_next = K_SELECTOR;
                            go_ret = 1'b1;
                        end
                        else
                        begin
                            tok_have_next = 1'b0;
                            if (tok_val_reg == {15'd0, run_code})
                            begin
                                stage_next = ST_RUN;
                            end
                            else if (tok_val_reg < {16'd0, lat_sel_reg})
                            begin
                                cur_sel_next = tok_val_reg[15:0];
                                stage_next = ST_FINISH;
                                if (lat_hist_reg != 10'd0)
                                begin
                                    hist_we = 1'b1;
                                    hist_wa = rover_reg[HIST_AW-1:0];
                                    hist_wd = tok_val_reg[15:0];
                                    rover_next = (rover_inc >= lat_hist_reg) ?
                                                 {1'b0, lat_hist_reg[9:1]} : rover_inc;
                                end
                            end
                            else if (slot_full >= {22'd0, lat_hist_reg})
                            begin
                                err_next = 1'b1; phase_next = K_DONE; go_ret = 1'b1;
                            end
                            else
                            begin
                                slot_next = slot_full[HIST_AW-1:0];
                                go_hist = 1'b1;
                            end
                        end
                    end
                    ST_RUN, ST_RUNVLC:
                    begin
                        if (!tok_have_reg)
                        begin
                            phase_next = (stage_reg == ST_RUN) ? K_RUN : K_RUNVLC;
                            go_ret = 1'b1;
                        end
                        else
                        begin
                            tok_have_next = 1'b0;
                            if ((stage_reg == ST_RUN) && (tok_val_reg == RUN_ESCAPE))
                            begin
                                stage_next = ST_RUNVLC;
                            end
                            else
                            begin
                                run_left_next = run_cnt;
                                if (lat_hist_reg == 10'd0)
                                begin
                                    err_next = 1'b1; phase_next = K_DONE; go_ret = 1'b1;
                                end
                                else
                                begin
                                    slot_next = '0;
                                    go_hist = 1'b1;
                                end
                            end
                        end
                    end
                    ST_FINISH:
                    begin
                        if (!may_end_reg)
                        begin
                            phase_next = K_ADVANCE;
                            go_ret = 1'b1;
                        end
                        else if ((cur_ep_reg >= {17'd0, lat_ep_reg}) || (cur_sel_reg >= lat_sel_reg))
                        begin
                            err_next = 1'b1; phase_next = K_DONE; go_ret = 1'b1;
                        end
                        else
                        begin
                            emitted_next = 1'b1;
                            emit_ep_next = cur_ep_reg[15:0];
                            emit_sel_next = cur_sel_reg;
                            stage_next = ST_PRED;
                            may_end_next = 1'b0;
                            if (col_inc >= lat_w_reg)
                            begin
                                col_next = '0;
                                row_next = row_inc[15:0];
                                if (row_inc >= {1'b0, lat_h_reg})
                                begin
                                    phase_next = K_DONE;
                                    go_ret = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_inc[COL_W-1:0];
                            end
                        end
                    end
                    default:
                    begin
                        stage_next = ST_PRED;
                    end
                endcase
            end
            SQ_STASH:
            begin
                cur_pred_next = stash_q[1:0];
                pend_next = {6'd0, stash_q[3:2]};
                stage_next = ST_ENDPOINT;
            end
            SQ_ROW:
            begin
                row_we = 1'b1;
                row_wd = row_q;
                last_ep_next = row_q;
                cur_ep_next = {17'd0, row_q};
                stage_next = ST_SELECTOR;
            end
            SQ_HRD:
            begin
                cur_sel_next = hist_qa;
                stage_next = ST_FINISH;
                if (slot_reg != '0)
                begin
                    hist_we = 1'b1;
                    hist_wa = slot_reg >> 1;
                    hist_wd = hist_qa;
                    swap_next = hist_qb;
                end
            end
            SQ_HWR:
            begin
                hist_we = 1'b1;
                hist_wa = slot_reg;
                hist_wd = swap_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (go_clear)
                    seq_next = SQ_CLEAR;
                else if (go_run)
                    seq_next = SQ_STEP;
            end
            SQ_CLEAR:
            begin
                if (clr_reg == '1)
                    seq_next = SQ_IDLE;
            end
            SQ_STEP:
            begin
                if (go_ret)
                    seq_next = SQ_IDLE;
                else if (go_stash)
                    seq_next = SQ_STASH;
                else if (go_row)
                    seq_next = SQ_ROW;
                else if (go_hist)
                    seq_next = SQ_HRD;
            end
            SQ_STASH, SQ_ROW, SQ_HWR:
            begin
                seq_next = SQ_STEP;
            end
            SQ_HRD:
            begin
                seq_next = (slot_reg != '0) ? SQ_HWR : SQ_STEP;
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_wa] <= row_wd;
        row_q <= row_mem[row_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stash_we)
            stash_mem[col_reg] <= stash_wd;
        stash_q <= stash_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_wa] <= hist_wd;
        hist_qa <= hist_mem[hist_ra_a];
        hist_qb <= hist_mem[hist_ra_b];
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= 11'd1;
            cfg_h_reg <= 16'd1;
            cfg_ep_reg <= 16'd1;
            cfg_sel_reg <= 16'd1;
            cfg_hist_reg <= 10'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WIDTH:  cfg_w_reg <= cfg_data[10:0];
                CFG_HEIGHT: cfg_h_reg <= cfg_data;
                CFG_EP:     cfg_ep_reg <= cfg_data;
                CFG_SEL:    cfg_sel_reg <= cfg_data;
                CFG_HIST:   cfg_hist_reg <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // control and slice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SQ_IDLE;
            stage_reg <= ST_PRED;
            phase_reg <= K_DONE;
            err_reg <= 1'b0;
            lat_w_reg <= 11'd1;
            lat_h_reg <= 16'd1;
            lat_ep_reg <= 16'd1;
            lat_sel_reg <= 16'd1;
            lat_hist_reg <= 10'd0;
            col_reg <= '0;
            row_reg <= 16'd0;
            pend_reg <= 8'd0;
            last_sym_reg <= 8'd0;
            rep_left_reg <= 32'd0;
            run_left_reg <= 32'd0;
            last_ep_reg <= 16'd0;
            cur_pred_reg <= 2'd0;
            cur_ep_reg <= 33'd0;
            cur_sel_reg <= 16'd0;
            tok_have_reg <= 1'b0;
            may_end_reg <= 1'b0;
            rover_reg <= '0;
            clr_reg <= '0;
            emitted_reg <= 1'b0;
            ib_valid_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            stage_reg <= stage_next;
            phase_reg <= phase_next;
            err_reg <= err_next;
            lat_w_reg <= lat_w_next;
            lat_h_reg <= lat_h_next;
            lat_ep_reg <= lat_ep_next;
            lat_sel_reg <= lat_sel_next;
            lat_hist_reg <= lat_hist_next;
            col_reg <= col_next;
            row_reg <= row_next;
            pend_reg <= pend_next;
            last_sym_reg <= last_sym_next;
            rep_left_reg <= rep_left_next;
            run_left_reg <= run_left_next;
            last_ep_reg <= last_ep_next;
            cur_pred_reg <= cur_pred_next;
            cur_ep_reg <= cur_ep_next;
            cur_sel_reg <= cur_sel_next;
            tok_have_reg <= tok_have_next;
            may_end_reg <= may_end_next;
            rover_reg <= rover_next;
            clr_reg <= clr_next;
            emitted_reg <= emitted_next;
            if (ib_take)
                ib_valid_reg <= 1'b0;
            else if (token_valid && !token_stall)
                ib_valid_reg <= 1'b1;
            if (go_ret)
                ov_reg <= 1'b1;
            else if (!result_stall)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tok_val_reg <= tok_val_next;
        slot_reg <= slot_next;
        swap_reg <= swap_next;
        emit_ep_reg <= emit_ep_next;
        emit_sel_reg <= emit_sel_next;
        if (token_valid && !token_stall)
        begin
            ib_kind_reg <= kind_t'(kind);
            ib_value_reg <= token_value;
        end
        if (go_ret)
        begin
            o_block_reg <= emitted_next;
            o_ep_reg <= emit_ep_next;
            o_sel_reg <= emit_sel_next;
            o_need_reg <= phase_next;
            o_err_reg <= err_next;
        end
    end

endmodule

`default_nettype wire

/* design/etc1s_bir_checker.sv */
// port-level checks for the etc1s block index rebuild, bound to the top level
// depends on etc1s_bir_pkg and etc1s_block_index_reconstruct
`timescale 1ns / 1ps
`default_nettype none

module etc1s_bir_checker
    import etc1s_bir_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        token_valid,
    input wire logic        token_stall,
    input wire logic [2:0]  kind,
    input wire logic [31:0] token_value,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic        block_valid,
    input wire logic [15:0] endpoint_index,
    input wire logic [15:0] selector_index,
    input wire logic [2:0]  need_kind,
    input wire logic        error,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [2:0]  cfg_index,
    input wire logic [15:0] cfg_data
);

    // a block never comes with the error flag
    a_block_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && block_valid |-> !error)
        else $error("block emitted with error");

    // an error always finishes the slice
    a_error_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && error |-> need_kind == K_DONE)
        else $error("error without slice finish");

    // no block means zero indices
    a_no_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !block_valid |-> endpoint_index == 16'd0 && selector_index == 16'd0)
        else $error("indices set without block");

    // a taken request stalls the input side in the next cycle
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_stall |=> token_stall)
        else $error("second request taken back to back");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(need_kind)
        && $stable(error) && $stable(block_valid))
        else $error("stalled result changed");

endmodule

bind etc1s_block_index_reconstruct etc1s_bir_checker u_etc1s_bir_checker (.*);

`default_nettype wire

/* dv/etc1s_index_checker.sv */
// watches the token, result and register channels of the etc1s block index rebuild,
// predicts each result and compares it field by field, counting mismatches
// depends on etc1s_bir_pkg
`timescale 1ns / 1ps

module etc1s_index_checker
    import etc1s_bir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        token_valid,
    input  logic        token_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] token_value,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic        block_valid,
    input  logic [15:0] endpoint_index,
    input  logic [15:0] selector_index,
    input  logic [2:0]  need_kind,
    input  logic        error,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fails,
    output int          waiting,
    output int          blocks_seen,
    output int          errors_seen
);

    typedef struct packed {
        logic        blk;
        logic [15:0] ep;
        logic [15:0] sel;
        logic [2:0]  need;
        logic        err;
    } block_result_t;

    block_result_t want_results[$];

    logic [31:0] reg_w, reg_h, reg_ep, reg_sel, reg_hist;
    logic [31:0] sl_w, sl_h, sl_ep, sl_sel, sl_hist;

    logic [15:0] row_ep   [2*MAX_COLS];
    logic [3:0]  stash    [2*MAX_COLS];
    logic [15:0] hist_val [HISTORY_DEPTH];
    logic [31:0] rover, col, row, pend, last_sym, rep_left, run_left, last_ep;
    logic [31:0] cur_pred, cur_sel, tok, out_ep, out_sel;
    logic [63:0] cur_ep;
    kind_t       phase;
    stage_t      stage;
    bit          err_flag, have, may_end;

    function automatic int ix(input logic [31:0] b, input logic [31:0] c);
        return int'(b[0]) * MAX_COLS + int'(c % MAX_COLS);
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic bit grab(input kind_t k, output logic [31:0] v);
        v = '0;
        if (!have)
        begin
            phase = k;
            return 0;
        end
        have = 0;
        v = tok;
        return 1;
    endfunction

    function automatic void fail_slice();
        err_flag = 1;
        phase = K_DONE;
    endfunction

    function automatic void take_pred();
        cur_pred = pend & 32'd3;
        pend = (pend >> 2) & 32'hFF;
        stage = ST_ENDPOINT;
    endfunction

    function automatic void stash_take();
        stash[ix(1, col)] = pend[7:4];
        take_pred();
    endfunction

    function automatic void hist_pick(input logic [31:0] slot);
        int a, h;
        logic [15:0] t;
        a = int'(slot % HISTORY_DEPTH);
        h = int'((slot / 2) % HISTORY_DEPTH);
        cur_sel = {16'd0, hist_val[a]};
        if (slot != 0)
        begin
            t = hist_val[h];
            hist_val[h] = hist_val[a];
            hist_val[a] = t;
        end
        stage = ST_FINISH;
    endfunction

    function automatic void hist_add(input logic [31:0] v);
        cur_sel = v;
        stage = ST_FINISH;
        if (sl_hist != 0)
        begin
            hist_val[int'(rover % HISTORY_DEPTH)] = v[15:0];
            rover++;
            if (rover >= sl_hist)
                rover = sl_hist / 2;
        end
    endfunction

    function automatic bit start_run(input logic [31:0] count);
        run_left = count - 1;
        if (sl_hist == 0)
        begin
            fail_slice();
            return 0;
        end
        hist_pick(0);
        return 1;
    endfunction

    function automatic bit rebuild_blocks();
        bit got, bad;
        logic [31:0] v, prev;
        logic [63:0] e;
        got = 0;
        while (1)
        begin
            prev = {31'd0, ~row[0]};
            case (stage)
                ST_PRED:
                begin
                    if (col[0])
                        take_pred();
                    else if (row[0])
                    begin
                        pend = {28'd0, stash[ix(1, col)]};
                        take_pred();
                    end
                    else if (rep_left != 0)
                    begin
                        rep_left--;
                        pend = last_sym;
                        stash_take();
                    end
                    else
                    begin
                        if (!grab(K_PRED, v))
                            return got;
                        if (v >= PRED_SYMBOL_COUNT)
                        begin
                            fail_slice();
                            return got;
                        end
                        if (v == PRED_ESCAPE)
                            stage = ST_REPEAT;
                        else
                        begin
                            pend = v;
                            last_sym = v;
                            stash_take();
                        end
                    end
                end
                ST_REPEAT:
                begin
                    if (!grab(K_REPEAT, v))
                        return got;
                    rep_left = sat_add(v, 32'd2);
                    pend = last_sym;
                    stash_take();
                end
                ST_ENDPOINT:
                begin
                    if (cur_pred == 3)
                    begin
                        if (!grab(K_DELTA, v))
                            return got;
                        e = {32'd0, v} + {32'd0, last_ep};
                        if (e >= {32'd0, sl_ep})
                            e = e - {32'd0, sl_ep};
                    end
                    else
                    begin
                        bad = (cur_pred != 1 && col == 0) || (cur_pred != 0 && row == 0);
                        if (bad)
                        begin
                            if (!may_end)
                                phase = K_ADVANCE;
                            else
                                fail_slice();
                            return got;
                        end
                        if (cur_pred == 0)
                            e = {32'd0, last_ep};
                        else if (cur_pred == 1)
                            e = {48'd0, row_ep[ix(prev, col)]};
                        else
                            e = {48'd0, row_ep[ix(prev, col - 1)]};
                    end
                    row_ep[ix(row, col)] = e[15:0];
                    last_ep = {16'd0, e[15:0]};
                    cur_ep = e;
                    stage = ST_SELECTOR;
                end
                ST_SELECTOR:
                begin
                    if (run_left != 0)
                    begin
                        if (sl_hist == 0)
                        begin
                            if (!may_end)
                                phase = K_ADVANCE;
                            else
                                fail_slice();
                            return got;
                        end
                        run_left--;
                        hist_pick(0);
                    end
                    else
                    begin
                        if (!grab(K_SELECTOR, v))
                            return got;
                        if ({32'd0, v} == {32'd0, sl_sel} + {32'd0, sl_hist})
                            stage = ST_RUN;
                        else if (v < sl_sel)
                            hist_add(v);
                        else if (v - sl_sel >= sl_hist)
                        begin
                            fail_slice();
                            return got;
                        end
                        else
                            hist_pick(v - sl_sel);
                    end
                end
                ST_RUN:
                begin
                    if (!grab(K_RUN, v))
                        return got;
                    if (v == RUN_ESCAPE)
                        stage = ST_RUNVLC;
                    else if (!start_run(sat_add(v, 32'd3)))
                        return got;
                end
                ST_RUNVLC:
                begin
                    if (!grab(K_RUNVLC, v))
                        return got;
                    if (!start_run(sat_add(v, 32'd3)))
                        return got;
                end
                default:
                begin
                    if (!may_end)
                    begin
                        phase = K_ADVANCE;
                        return got;
                    end
                    if (cur_ep >= {32'd0, sl_ep} || cur_sel >= sl_sel)
                    begin
                        fail_slice();
                        return got;
                    end
                    out_ep = cur_ep[31:0];
                    out_sel = cur_sel;
                    got = 1;
                    col++;
                    if (col >= sl_w)
                    begin
                        col = 0;
                        row++;
                        if (row >= sl_h)
                        begin
                            phase = K_DONE;
                            return got;
                        end
                    end
                    stage = ST_PRED;
                    may_end = 0;
                end
            endcase
        end
        return got;
    endfunction

    function automatic void start_slice();
        sl_w = reg_w;
        sl_h = reg_h;
        sl_ep = reg_ep;
        sl_sel = reg_sel;
        sl_hist = reg_hist;
        for (int i = 0; i < 2*MAX_COLS; i++)
        begin
            row_ep[i] = '0;
            stash[i] = '0;
        end
        for (int i = 0; i < HISTORY_DEPTH; i++)
            hist_val[i] = '0;
        rover = sl_hist / 2;
        col = 0;
        row = 0;
        pend = 0;
        last_sym = 0;
        rep_left = 0;
        run_left = 0;
        last_ep = 0;
        stage = ST_PRED;
        cur_pred = 0;
        cur_sel = 0;
        cur_ep = 0;
        err_flag = 0;
        phase = K_DONE;
        if (sl_w > MAX_COLS || sl_hist > HISTORY_DEPTH || sl_ep == 0 || sl_sel == 0)
        begin
            err_flag = 1;
            return;
        end
        if (sl_w == 0 || sl_h == 0)
            return;
        have = 0;
        may_end = 0;
        void'(rebuild_blocks());
    endfunction

    function automatic block_result_t predict_token(input kind_t k, input logic [31:0] v);
        block_result_t r;
        bit got;
        got = 0;
        out_ep = 0;
        out_sel = 0;
        if (k == K_START)
            start_slice();
        else if (k == phase && k <= K_RUNVLC)
        begin
            have = 1;
            tok = v;
            may_end = 1;
            got = rebuild_blocks();
        end
        else if (k == K_ADVANCE && phase == K_ADVANCE)
        begin
            have = 0;
            may_end = 1;
            got = rebuild_blocks();
        end
        r.blk = got;
        r.ep = got ? out_ep[15:0] : 16'd0;
        r.sel = got ? out_sel[15:0] : 16'd0;
        r.need = phase;
        r.err = err_flag;
        return r;
    endfunction

    assign waiting = want_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        block_result_t w;
        if (!rst_n)
        begin
            reg_w = 1;
            reg_h = 1;
            reg_ep = 1;
            reg_sel = 1;
            reg_hist = 0;
            start_slice();
            err_flag = 0;
            phase = K_DONE;
            want_results.delete();
            fails <= 0;
            blocks_seen <= 0;
            errors_seen <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  reg_w = {21'd0, cfg_data[10:0]};
                    CFG_HEIGHT: reg_h = {16'd0, cfg_data};
                    CFG_EP:     reg_ep = {16'd0, cfg_data};
                    CFG_SEL:    reg_sel = {16'd0, cfg_data};
                    CFG_HIST:   reg_hist = {22'd0, cfg_data[9:0]};
                    default: ;
                endcase
            end
            if (token_valid && !token_stall)
                want_results.push_back(predict_token(kind_t'(kind), token_value));
            if (result_valid && !result_stall)
            begin
                blocks_seen <= blocks_seen + int'(block_valid);
                errors_seen <= errors_seen + int'(error);
                if (want_results.size() == 0)
                begin
                    if (fails < 10)
                        $display("unexpected result at %0t: blk %0b need %0d", $time,
                                 block_valid, need_kind);
                    fails <= fails + 1;
                end
                else
                begin
                    w = want_results.pop_front();
                    if (w.blk !== block_valid || w.ep !== endpoint_index
                        || w.sel !== selector_index || w.need !== need_kind
                        || w.err !== error)
                    begin
                        if (fails < 10)
                            $display({"mismatch at %0t: exp blk %0b ep %0d sel %0d need %0d ",
                                      "err %0b, got blk %0b ep %0d sel %0d need %0d err %0b"},
                                     $time, w.blk, w.ep, w.sel, w.need, w.err, block_valid,
                                     endpoint_index, selector_index, need_kind, error);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

/* dv/etc1s_block_index_reconstruct_test.sv */
// stimulus and verdict for the etc1s block index rebuild: register settings,
// directed and random token sequences, random gaps between tokens and random result stalls
// depends on etc1s_bir_pkg, etc1s_block_index_reconstruct and etc1s_index_checker
`timescale 1ns / 1ps

module etc1s_block_index_reconstruct_test;
    import etc1s_bir_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        token_valid;
    logic        token_stall;
    logic [2:0]  kind;
    logic [31:0] token_value;
    logic        result_valid;
    logic        result_stall;
    logic        block_valid;
    logic [15:0] endpoint_index;
    logic [15:0] selector_index;
    logic [2:0]  need_kind;
    logic        error;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    int fails, waiting, blocks_seen, errors_seen;
    int sent, got_results, idle_cycles, slices, stall_left;
    bit calm;
    kind_t last_need;
    logic [31:0] c_w, c_h, c_ep, c_sel, c_hist;

    etc1s_block_index_reconstruct DUT (.*);

    etc1s_index_checker checker_inst (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_left <= gap_len();
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            got_results <= 0;
            last_need <= K_DONE;
            idle_cycles <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got_results <= got_results + 1;
                last_need <= kind_t'(need_kind);
            end
            if ((result_valid && !result_stall) || (token_valid && !token_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic push_token(input kind_t k, input logic [31:0] v);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            token_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        token_valid <= 1'b1;
        kind <= k;
        token_value <= v;
        do
            @(posedge clk);
        while (token_stall);
        token_valid <= 1'b0;
        sent++;
        if (k == K_START)
            slices++;
        while (got_results != sent)
            @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] w, input logic [15:0] h, input logic [15:0] ep,
                            input logic [15:0] sel, input logic [15:0] hl);
        logic [15:0] vals [5];
        vals = '{w, h, ep, sel, hl};
        // let any clearing pass or trailing work drain first
        repeat (700) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        c_w = {21'd0, w[10:0]};
        c_h = {16'd0, h};
        c_ep = {16'd0, ep};
        c_sel = {16'd0, sel};
        c_hist = {22'd0, hl[9:0]};
    endtask

    function automatic logic [31:0] below(input logic [31:0] n);
        return (n == 0) ? 32'd0 : $urandom_range(0, n - 1);
    endfunction

    function automatic logic [31:0] value_for(input kind_t k);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return $urandom;
        case (k)
            K_PRED:
                if (r < 40) return 32'hFF;
                else if (r < 50) return PRED_ESCAPE;
                else if (r < 53) return PRED_SYMBOL_COUNT + $urandom_range(0, 9);
                else return $urandom_range(0, 255);
            K_REPEAT:
                if (r < 8) return 32'hFFFF_FFFF;
                else return $urandom_range(0, 6);
            K_DELTA:
                return below(c_ep);
            K_SELECTOR:
                if (r < 50) return below(c_sel);
                else if (r < 75) return c_sel + below(c_hist);
                else if (r < 90) return c_sel + c_hist;
                else return c_sel + c_hist + $urandom_range(1, 3);
            K_RUN:
                if (r < 15) return RUN_ESCAPE;
                else return $urandom_range(0, 8);
            K_RUNVLC:
                if (r < 8) return 32'hFFFF_FFFF;
                else return $urandom_range(0, 20);
            default:
                return $urandom;
        endcase
    endfunction

    task automatic random_tokens(input int n);
        kind_t k;
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 10)
                k = kind_t'($urandom_range(0, 7));
            else if (last_need == K_DONE)
                k = K_START;
            else
                k = last_need;
            push_token(k, value_for(k));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        token_valid = 1'b0;
        kind = K_PRED;
        token_value = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        sent = 0;
        slices = 0;
        calm = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: escapes, runs, saturating counts, wrong kinds, bad predictions
        set_regs(16'd2, 16'd2, 16'd8, 16'd4, 16'd4);
        push_token(K_START, 32'd0);
        push_token(K_SELECTOR, 32'd1);
        push_token(K_PRED, PRED_ESCAPE);
        push_token(K_REPEAT, 32'hFFFF_FFFF);
        push_token(K_DELTA, 32'd7);
        push_token(K_SELECTOR, 32'd8);
        push_token(K_RUN, RUN_ESCAPE);
        push_token(K_RUNVLC, 32'hFFFF_FFFF);
        push_token(K_ADVANCE, 32'd0);
        push_token(K_DELTA, 32'd1);
        push_token(K_ADVANCE, 32'd0);
        push_token(K_DELTA, 32'hFFFF_FFFF);
        push_token(K_ADVANCE, 32'd0);
        push_token(K_START, 32'd0);
        push_token(K_PRED, 32'd300);
        push_token(K_ADVANCE, 32'd0);
        push_token(K_START, 32'd0);
        push_token(K_PRED, 32'd0);
        push_token(K_ADVANCE, 32'd0);
        push_token(K_START, 32'd0);
        push_token(K_PRED, 32'hFF);
        push_token(K_DELTA, 32'd3);
        push_token(K_SELECTOR, 32'd7);
        push_token(K_SELECTOR, 32'd5);
        push_token(K_SELECTOR, 32'd0);

        random_tokens(120);
        set_regs(16'd4, 16'd4, 16'd16, 16'd8, 16'd8);
        random_tokens(150);
        set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
        random_tokens(100);
        set_regs(16'd3, 16'd5, 16'hFFFF, 16'hFFFF, 16'd512);
        random_tokens(150);
        set_regs(16'd1024, 16'd1, 16'd100, 16'd50, 16'd16);
        random_tokens(120);
        set_regs(16'd5, 16'd3, 16'd7, 16'd3, 16'd0);
        random_tokens(130);
        set_regs(16'd0, 16'd3, 16'd8, 16'd8, 16'd4);
        random_tokens(10);
        set_regs(16'd3, 16'd0, 16'd8, 16'd8, 16'd4);
        random_tokens(10);
        set_regs(16'd1025, 16'd2, 16'd8, 16'd8, 16'd4);
        random_tokens(10);
        set_regs(16'd4, 16'd4, 16'd0, 16'd8, 16'd4);
        random_tokens(10);
        set_regs(16'd4, 16'd4, 16'd8, 16'd0, 16'd4);
        random_tokens(10);
        set_regs(16'd4, 16'd4, 16'd8, 16'd8, 16'd513);
        random_tokens(10);
        set_regs(16'hFFFF, 16'd2, 16'd8, 16'd8, 16'hFFFF);
        random_tokens(10);
        set_regs(16'd2, 16'hFFFF, 16'd300, 16'd20, 16'd32);
        random_tokens(150);
        set_regs(16'd6, 16'd6, 16'd40, 16'd10, 16'd3);
        random_tokens(200);
        set_regs(16'd8, 16'd2, 16'hFFFF, 16'd1, 16'd1);
        random_tokens(150);
        set_regs(16'd3, 16'd3, 16'd5, 16'd6, 16'd2);
        random_tokens(200);

        while (waiting != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("run covered %0d tokens over %0d slice starts and 17 register settings",
                 sent, slices);
        $display("results carried %0d blocks and %0d with the error flag, %0d mismatches",
                 blocks_seen, errors_seen, fails);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/etc1s_bir_pkg.sv
design/etc1s_block_index_reconstruct.sv
design/etc1s_bir_checker.sv
dv/etc1s_index_checker.sv
dv/etc1s_block_index_reconstruct_test.sv
